>>> rtl/core/bitmap_rect_fill_and_rotate_macros.svh
// Assertion macros for the screen block.
`ifndef BITMAP_RECT_FILL_AND_ROTATE_MACROS_SVH
`define BITMAP_RECT_FILL_AND_ROTATE_MACROS_SVH

`ifndef SYNTHESIS
`define BRFR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BRFR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BRFR_ASSERT_IMP(label, ante, cons, msg)
`define BRFR_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/core/brfr_pkg.sv
package brfr_pkg;

	typedef enum logic [1:0] {
		FN_RECT     = 2'd0,
		FN_ROT_ROW  = 2'd1,
		FN_ROT_COL  = 2'd2,
		FN_READ_ROW = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_GATHER,
		ST_SWEEP,
		ST_DONE
	} state_t;

	localparam logic REG_ACTIVE_WIDTH  = 1'b0;
	localparam logic REG_ACTIVE_HEIGHT = 1'b1;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 8;

	localparam int FUNC_W     = 2;
	localparam int OPA_W      = 7;
	localparam int OPB_W      = 6;
	localparam int AW_REG_W   = 7;
	localparam int AH_REG_W   = 4;
	localparam int ROW_BITS_W = 64;
	localparam int LIT_W      = 10;
	localparam int SUM_W      = 13;
	localparam int MOD_STEPS  = 6;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 80;

	localparam logic [AW_REG_W-1:0] RST_ACTIVE_WIDTH  = 7'd50;
	localparam logic [AH_REG_W-1:0] RST_ACTIVE_HEIGHT = 4'd6;
	localparam logic [SUM_W-1:0]    LIT_MAX           = 13'd1023;

endpackage

>>> rtl/core/bitmap_rect_fill_and_rotate.sv
// Channel   | Signals                                   | Beat
// ----------+-------------------------------------------+---------------------------
// command   | s_tvalid s_tready s_tdata s_tuser         | one command in
// result    | m_tvalid m_tready m_tdata m_tuser         | one result per command
// config    | cfg_we cfg_idx cfg_wdata                  | one register write
//
// One command at a time. Rect fill and read row make one sweep over the active rows:
// each active row is read from the row memory, modified and written back, and counted.
// A valid row rotate first runs the bit-serial modulo unit; a valid column rotate
// runs it too and then a gather pass that collects the column before the sweep.
// Reset clears the per-row valid flags at once, so the screen reads blank; no sweep.
// A waiting result does not block the next command; a finished command holds in its
// last cycle while the previous result is still unread.
`include "bitmap_rect_fill_and_rotate_macros.svh"

module bitmap_rect_fill_and_rotate #(
	parameter int MAX_WIDTH  = brfr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = brfr_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [6:0] first_operand, [12:7] second_operand, [15:13] zero
	input  logic [brfr_pkg::IN_DATA_W-1:0]      s_tdata,
	// [1:0] func
	input  logic [brfr_pkg::FUNC_W-1:0]         s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [63:0] row_bits, [73:64] lit_count, [79:74] zero
	output logic [brfr_pkg::OUT_DATA_W-1:0]     m_tdata,
	// [0] index_error
	output logic [0:0]                          m_tuser,
	input  logic                                cfg_we,
	input  logic                                cfg_idx,
	input  logic [brfr_pkg::AW_REG_W-1:0]       cfg_wdata
);

	localparam int HW  = $clog2(MAX_HEIGHT);
	localparam int HCW = $clog2(MAX_HEIGHT + 1);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

	brfr_pkg::state_t state_q, state_d;

	logic [brfr_pkg::AW_REG_W-1:0] aw_q;
	logic [brfr_pkg::AH_REG_W-1:0] ah_q;

	brfr_pkg::func_t              func_q;
	logic [brfr_pkg::OPA_W-1:0]   a_q;
	logic [brfr_pkg::OPB_W-1:0]   b_q;
	logic                         err_q;

	logic [2:0]                   step_q;
	logic [brfr_pkg::OPB_W-1:0]   rem_q;
	logic [HCW-1:0]               row_q;
	logic [MAX_HEIGHT-1:0]        col_q;
	logic [MAX_HEIGHT-1:0]        row_vld_q;
	logic [AW-1:0]                acc_q;
	logic [MAX_WIDTH-1:0]         row_out_q;

	logic [MAX_WIDTH-1:0]         mem [MAX_HEIGHT];
	logic [MAX_WIDTH-1:0]         rdata_s1;
	logic                         vld_s1;
	logic [HW-1:0]                addr_s1;
	logic                         vld_s2;
	logic [MAX_WIDTH-1:0]         pop_s2;

	logic                         m_vld_q;
	logic [MAX_WIDTH-1:0]         m_row_q;
	logic [brfr_pkg::LIT_W-1:0]   m_lit_q;
	logic                         m_err_q;

	logic                         accept;
	logic                         issue;
	logic                         pass_done;
	logic                         load_out;
	logic                         mod_last;

	logic [6:0]                   w7;
	logic [6:0]                   h7;
	logic [6:0]                   w_eff;
	logic [HCW-1:0]               h_eff;
	logic [MAX_WIDTH-1:0]         wmask;
	logic [MAX_HEIGHT-1:0]        hmask;

	brfr_pkg::func_t              in_func;
	logic [brfr_pkg::OPA_W-1:0]   in_a;
	logic [brfr_pkg::OPB_W-1:0]   in_b;
	logic                         in_err;

	logic [6:0]                   mod_div;
	logic [6:0]                   mod_trial;
	logic [brfr_pkg::OPB_W-1:0]   mod_next;

	logic [6:0]                   fw;
	logic [6:0]                   fh;
	logic [MAX_WIDTH-1:0]         fmask;
	logic [MAX_WIDTH-1:0]         cur;
	logic [MAX_WIDTH-1:0]         cur_act;
	logic [MAX_WIDTH-1:0]         row_rot;
	logic [MAX_HEIGHT-1:0]        col_rot;
	logic [MAX_WIDTH-1:0]         newrow;
	logic                         hit_row;
	logic [brfr_pkg::SUM_W-1:0]   acc_wide;

	// effective sizes
	always_comb begin
		h7 = {3'b000, ah_q};
		if (aw_q == 7'd0) begin
			w7 = 7'd1;
		end else if (aw_q > 7'(MAX_WIDTH)) begin
			w7 = 7'(MAX_WIDTH);
		end else begin
			w7 = aw_q;
		end
		w_eff = w7;
		if (h7 == 7'd0) begin
			h_eff = HCW'(1);
		end else if (h7 > 7'(MAX_HEIGHT)) begin
			h_eff = HCW'(MAX_HEIGHT);
		end else begin
			h_eff = HCW'(h7);
		end
		wmask = ~({MAX_WIDTH{1'b1}} << w_eff);
		hmask = ~({MAX_HEIGHT{1'b1}} << h_eff);
	end

	assign in_func = brfr_pkg::func_t'(s_tuser);
	assign in_a    = s_tdata[6:0];
	assign in_b    = s_tdata[12:7];

	always_comb begin
		case (in_func)
			brfr_pkg::FN_ROT_ROW, brfr_pkg::FN_READ_ROW: in_err = in_a >= 7'(h_eff);
			brfr_pkg::FN_ROT_COL:                        in_err = in_a >= w_eff;
			default:                                     in_err = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			brfr_pkg::ST_IDLE: begin
				if (accept) begin
					if (!in_err && (in_func == brfr_pkg::FN_ROT_ROW ||
					                in_func == brfr_pkg::FN_ROT_COL)) begin
						state_d = brfr_pkg::ST_MOD;
					end else begin
						state_d = brfr_pkg::ST_SWEEP;
					end
				end
			end
			brfr_pkg::ST_MOD: begin
				if (mod_last) begin
					state_d = (func_q == brfr_pkg::FN_ROT_COL) ? brfr_pkg::ST_GATHER
					                                           : brfr_pkg::ST_SWEEP;
				end
			end
			brfr_pkg::ST_GATHER: begin
				if (pass_done) begin
					state_d = brfr_pkg::ST_SWEEP;
				end
			end
			brfr_pkg::ST_SWEEP: begin
				if (pass_done) begin
					state_d = brfr_pkg::ST_DONE;
				end
			end
			brfr_pkg::ST_DONE: begin
				if (load_out) begin
					state_d = brfr_pkg::ST_IDLE;
				end
			end
			default: state_d = brfr_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready  = 1'b0;
		issue     = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			brfr_pkg::ST_IDLE:   s_tready = 1'b1;
			brfr_pkg::ST_GATHER: issue    = row_q < h_eff;
			brfr_pkg::ST_SWEEP:  issue    = row_q < h_eff;
			brfr_pkg::ST_DONE:   load_out = !m_vld_q || m_tready;
			default: ;
		endcase
	end

	assign accept    = s_tvalid && s_tready;
	assign pass_done = (row_q == h_eff) && !vld_s1 && !vld_s2;
	assign mod_last  = step_q == 3'd0;

	// bit-serial modulo: one dividend bit per cycle
	always_comb begin
		mod_div   = (func_q == brfr_pkg::FN_ROT_ROW) ? w_eff : 7'(h_eff);
		mod_trial = {rem_q, b_q[step_q]};
		mod_next  = (mod_trial >= mod_div) ? brfr_pkg::OPB_W'(mod_trial - mod_div)
		                                   : brfr_pkg::OPB_W'(mod_trial);
	end

	// row modify
	always_comb begin
		fw      = (a_q > w_eff) ? w_eff : a_q;
		fh      = ({1'b0, b_q} > 7'(h_eff)) ? 7'(h_eff) : {1'b0, b_q};
		fmask   = ~({MAX_WIDTH{1'b1}} << fw);
		cur     = row_vld_q[addr_s1] ? rdata_s1 : '0;
		cur_act = cur & wmask;
		row_rot = ((cur_act << rem_q) | (cur_act >> (w_eff - {1'b0, rem_q}))) & wmask;
		col_rot = (((col_q & hmask) << rem_q) |
		           ((col_q & hmask) >> (7'(h_eff) - {1'b0, rem_q}))) & hmask;
		hit_row = 7'(addr_s1) == a_q;
		newrow  = cur;
		case (func_q)
			brfr_pkg::FN_RECT: begin
				if (7'(addr_s1) < fh) begin
					newrow = cur | fmask;
				end
			end
			brfr_pkg::FN_ROT_ROW: begin
				if (!err_q && hit_row) begin
					newrow = (cur & ~wmask) | row_rot;
				end
			end
			brfr_pkg::FN_ROT_COL: begin
				if (!err_q) begin
					newrow[a_q[CW-1:0]] = col_rot[addr_s1];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= brfr_pkg::ST_IDLE;
			aw_q      <= brfr_pkg::RST_ACTIVE_WIDTH;
			ah_q      <= brfr_pkg::RST_ACTIVE_HEIGHT;
			row_vld_q <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			m_vld_q   <= 1'b0;
			row_q     <= '0;
			step_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					brfr_pkg::REG_ACTIVE_WIDTH:  aw_q <= cfg_wdata;
					brfr_pkg::REG_ACTIVE_HEIGHT: ah_q <= cfg_wdata[brfr_pkg::AH_REG_W-1:0];
					default: ;
				endcase
			end
			if (state_q != state_d) begin
				row_q <= '0;
			end else if (issue) begin
				row_q <= row_q + HCW'(1);
			end
			if (accept) begin
				step_q <= 3'(brfr_pkg::MOD_STEPS - 1);
			end else if (state_q == brfr_pkg::ST_MOD && !mod_last) begin
				step_q <= step_q - 3'd1;
			end
			vld_s1 <= issue;
			vld_s2 <= vld_s1 && state_q == brfr_pkg::ST_SWEEP;
			if (vld_s1 && state_q == brfr_pkg::ST_SWEEP) begin
				row_vld_q[addr_s1] <= 1'b1;
			end
			if (load_out) begin
				m_vld_q <= 1'b1;
			end else if (m_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= in_func;
			a_q       <= in_a;
			b_q       <= in_b;
			err_q     <= in_err;
			rem_q     <= '0;
			acc_q     <= '0;
			row_out_q <= '0;
		end else begin
			if (state_q == brfr_pkg::ST_MOD) begin
				rem_q <= mod_next;
			end
			if (vld_s1 && state_q == brfr_pkg::ST_GATHER) begin
				col_q[addr_s1] <= cur[a_q[CW-1:0]];
			end
			if (vld_s1 && state_q == brfr_pkg::ST_SWEEP && func_q == brfr_pkg::FN_READ_ROW &&
			    !err_q && hit_row) begin
				row_out_q <= cur_act;
			end
			if (vld_s2) begin
				acc_q <= acc_q + AW'($countones(pop_s2));
			end
		end
		addr_s1 <= row_q[HW-1:0];
		pop_s2  <= newrow & wmask;
		if (load_out) begin
			m_row_q <= row_out_q;
			m_lit_q <= brfr_pkg::LIT_W'((acc_wide > brfr_pkg::LIT_MAX) ? brfr_pkg::LIT_MAX
			                                                           : acc_wide);
			m_err_q <= err_q;
		end
	end

	assign acc_wide = brfr_pkg::SUM_W'(acc_q);

	// row memory
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[row_q[HW-1:0]];
		end
		if (vld_s1 && state_q == brfr_pkg::ST_SWEEP) begin
			mem[addr_s1] <= newrow;
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = {6'b000000, m_lit_q, brfr_pkg::ROW_BITS_W'(m_row_q)};
	assign m_tuser  = m_err_q;

	`BRFR_ASSERT_NXT(a_accept_starts, accept, state_q != brfr_pkg::ST_IDLE, "command not started")
	`BRFR_ASSERT_IMP(a_addr_active, vld_s1, 7'(addr_s1) < 7'(h_eff), "row beyond active rows")
	`BRFR_ASSERT_IMP(a_count_in_sweep, vld_s2, state_q == brfr_pkg::ST_SWEEP, "count outside sweep")
	`BRFR_ASSERT_IMP(a_err_keeps_row, vld_s1 && err_q && state_q == brfr_pkg::ST_SWEEP,
		newrow == cur, "bad index modified a row")

endmodule
